/* src/lrcm_pkg.sv */
// Shared types, constants and helper functions of the luma-ranked colour median filter.
// No dependencies; every other file refers to this package by scoped names.

package lrcm_pkg;

  // Signed position wide enough for padded row and column arithmetic.
  localparam int unsigned PosW = 16;
  typedef logic signed [PosW-1:0] pos_t;

  localparam int unsigned CfgW      = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ResCntW   = 4;
  localparam int unsigned MaxResults = 16;

  // Q0.16 luma weights for blue, green and red.
  localparam logic [15:0] GrayWB = 16'd7471;
  localparam logic [15:0] GrayWG = 16'd38470;
  localparam logic [15:0] GrayWR = 16'd19595;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pix_blue;
    logic [7:0] pix_green;
    logic [7:0] pix_red;
  } pix_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic        window_error;
    logic        last_of_run;
    logic        frame_end;
  } res_t;

  // One word of the line store: luma key followed by the colour.
  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } spx_t;

  // Reflect an index about the image edges, then clamp what is still outside.
  function automatic pos_t mirror(input pos_t x, input pos_t n);
    pos_t y;
    if (x < 0) begin
      y = -x - pos_t'(1);
    end else if (x >= n) begin
      y = (n <<< 1) - pos_t'(1) - x;
    end else begin
      y = x;
    end
    if (y < 0) begin
      y = '0;
    end
    if (y > n - pos_t'(1)) begin
      y = n - pos_t'(1);
    end
    return y;
  endfunction

endpackage

/* src/lrcm_cell.sv */
// One cell of the ranking chain: holds a parked window element and its rank.
// Depends on lrcm_pkg for the store word type.

module lrcm_cell #(
  parameter int unsigned RankW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic [RankW-1:0]  tgt_i,
  input  logic              trv_vld_i,
  input  lrcm_pkg::spx_t    trv_px_i,
  input  logic [RankW-1:0]  trv_rank_i,
  input  lrcm_pkg::spx_t    res_i,
  output logic              trv_vld_o,
  output lrcm_pkg::spx_t    trv_px_o,
  output logic [RankW-1:0]  trv_rank_o,
  output lrcm_pkg::spx_t    res_o
);

  logic             st_vld_q;
  lrcm_pkg::spx_t   st_px_q;
  logic [RankW-1:0] st_rank_q;
  logic             trv_vld_q;
  lrcm_pkg::spx_t   trv_px_q;
  logic [RankW-1:0] trv_rank_q;
  lrcm_pkg::spx_t   res_q;
  logic             hit, park, match;

  assign hit   = trv_vld_i && st_vld_q;
  assign park  = trv_vld_i && !st_vld_q;
  assign match = st_vld_q && (st_rank_q == tgt_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q  <= 1'b0;
      trv_vld_q <= 1'b0;
    end else if (clr_i) begin
      st_vld_q  <= 1'b0;
      trv_vld_q <= 1'b0;
    end else begin
      if (park) begin
        st_vld_q <= 1'b1;
      end
      trv_vld_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (park) begin
      st_px_q   <= trv_px_i;
      st_rank_q <= trv_rank_i;
    end else if (hit && (trv_px_i.gray < st_px_q.gray)) begin
      st_rank_q <= st_rank_q + RankW'(1);
    end
    trv_px_q   <= trv_px_i;
    trv_rank_q <= trv_rank_i + RankW'(st_px_q.gray <= trv_px_i.gray);
    res_q      <= match ? st_px_q : res_i;
  end

  assign trv_vld_o  = trv_vld_q;
  assign trv_px_o   = trv_px_q;
  assign trv_rank_o = trv_rank_q;
  assign res_o      = res_q;

endmodule

/* src/lrcm_rank_chain.sv */
// Row of ranking cells; window elements travel down it and park in order.
// Depends on lrcm_pkg and lrcm_cell.

module lrcm_rank_chain #(
  parameter int unsigned NumCells = 49,
  parameter int unsigned RankW    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic [RankW-1:0] tgt_i,
  input  logic             in_vld_i,
  input  lrcm_pkg::spx_t   in_px_i,
  output lrcm_pkg::spx_t   res_o
);

  logic             vld  [NumCells+1];
  lrcm_pkg::spx_t   px   [NumCells+1];
  logic [RankW-1:0] rank [NumCells+1];
  lrcm_pkg::spx_t   res  [NumCells+1];

  assign vld[0]  = in_vld_i;
  assign px[0]   = in_px_i;
  assign rank[0] = '0;
  assign res[0]  = '0;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    lrcm_cell #(.RankW(RankW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (clr_i),
      .tgt_i      (tgt_i),
      .trv_vld_i  (vld[i]),
      .trv_px_i   (px[i]),
      .trv_rank_i (rank[i]),
      .res_i      (res[i]),
      .trv_vld_o  (vld[i+1]),
      .trv_px_o   (px[i+1]),
      .trv_rank_o (rank[i+1]),
      .res_o      (res[i+1])
    );
  end

  assign res_o = res[NumCells];

endmodule

/* src/lrcm_line_store.sv */
// Line store: single write port and one registered read port.
// Depends on lrcm_pkg for the store word type.

module lrcm_line_store #(
  parameter int unsigned Depth = 7168,
  parameter int unsigned AddrW = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  lrcm_pkg::spx_t   wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output lrcm_pkg::spx_t   rdata_o
);

  lrcm_pkg::spx_t mem [Depth];
  lrcm_pkg::spx_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/luma_ranked_color_median_filter.sv */
// Top level of the luma-ranked colour median filter: control, addressing and output beat.
// Depends on lrcm_pkg, lrcm_line_store and lrcm_rank_chain.
//
//  Channel | Signals                               | Beat moves
//  --------+---------------------------------------+-------------------------------
//  input   | in_valid_i, in_stall_o, in_data_i     | one BGR pixel in raster order
//  output  | out_valid_o, out_stall_i, out_data_o  | one filtered pixel with flags
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i       | one register write, no wait
//
// For each result the window is read from the line store one word a cycle, the wait covers
// every word travelling the full rank chain, and the median is swept down the chain.
// Reset clears control state; the line store is not cleared. Input stall is high until
// every result of the current beat has entered the output register; a finished result
// waits in the output register without blocking the next input beat.

module luma_ranked_color_median_filter #(
  parameter int unsigned MAX_WINDOW = 7,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lrcm_pkg::pix_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lrcm_pkg::res_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lrcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lrcm_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned NumCells = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned RankW    = $clog2(NumCells);
  localparam int unsigned SlotW    = $clog2(MAX_WINDOW);
  localparam int unsigned ColIdxW  = $clog2(MAX_WIDTH);
  localparam int unsigned Depth    = MAX_WINDOW * MAX_WIDTH;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned WaitCnt  = 3 * NumCells + 4;
  localparam int unsigned TmrW     = $clog2(WaitCnt + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_LOAD,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // Configuration registers.
  logic [2:0]  ws_q;
  logic [10:0] width_q;
  logic [12:0] height_q;

  // Position of the next input pixel and the store slot of its row.
  lrcm_pkg::pos_t in_row_q, in_col_q;
  logic [SlotW-1:0] in_slot_q;

  state_e state_q, state_d;

  // Run of results caused by the beat just taken.
  lrcm_pkg::pos_t rin_q, cur_r_q, cur_c_q, c0_q, c1_q, r1_q;
  logic [SlotW-1:0] slot_q;
  logic             last_r_q, last_c_q, err_q;
  lrcm_pkg::spx_t   pass_px_q;
  logic [lrcm_pkg::ResCntW-1:0] cnt_q;
  logic [2:0]       k_q, l_q;
  logic [TmrW-1:0]  tmr_q;
  logic             rd_vld_q;

  logic           out_valid_q;
  lrcm_pkg::res_t out_q;

  // Effective frame size with out-of-range settings clamped.
  lrcm_pkg::pos_t w_eff, h_eff, half;
  logic win_ok;

  always_comb begin
    if (width_q == '0) begin
      w_eff = lrcm_pkg::pos_t'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = lrcm_pkg::pos_t'(MAX_WIDTH);
    end else begin
      w_eff = lrcm_pkg::pos_t'(width_q);
    end
    if (height_q == '0) begin
      h_eff = lrcm_pkg::pos_t'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = lrcm_pkg::pos_t'(MAX_HEIGHT);
    end else begin
      h_eff = lrcm_pkg::pos_t'(height_q);
    end
  end

  assign half   = lrcm_pkg::pos_t'(ws_q >> 1);
  assign win_ok = (ws_q >= 3'd3) && ws_q[0] && (32'(ws_q) <= MAX_WINDOW);

  // A write to any existing register restarts the frame.
  logic cfg_hit;

  assign cfg_hit = (cfg_idx_i == lrcm_pkg::CFG_WINDOW) || (cfg_idx_i == lrcm_pkg::CFG_WIDTH) ||
                   (cfg_idx_i == lrcm_pkg::CFG_HEIGHT);

  // The accept path: luma key and store write.
  logic           accept, last_r, last_c, go;
  logic [23:0]    luma_sum;
  lrcm_pkg::spx_t wpx;
  logic [AddrW-1:0] waddr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign last_r     = (in_row_q == h_eff - lrcm_pkg::pos_t'(1));
  assign last_c     = (in_col_q == w_eff - lrcm_pkg::pos_t'(1));
  assign go         = (last_r || in_row_q >= half) && (last_c || in_col_q >= half);

  assign luma_sum = 24'(lrcm_pkg::GrayWB * 24'(in_data_i.pix_blue))
                  + 24'(lrcm_pkg::GrayWG * 24'(in_data_i.pix_green))
                  + 24'(lrcm_pkg::GrayWR * 24'(in_data_i.pix_red));

  always_comb begin
    wpx.gray  = luma_sum[23:16];
    wpx.red   = in_data_i.pix_red;
    wpx.green = in_data_i.pix_green;
    wpx.blue  = in_data_i.pix_blue;
  end

  assign waddr = AddrW'(in_slot_q) * AddrW'(MAX_WIDTH) + AddrW'(in_col_q[ColIdxW-1:0]);

  // Window read addressing: mirror the padded position, then find the row's slot
  // from its distance to the newest row, which is always at most the window span.
  lrcm_pkg::pos_t rr, cc, row_gap;
  logic [SlotW:0] d_s, s_ext, s_fix;
  logic [AddrW-1:0] raddr;

  always_comb begin
    rr      = lrcm_pkg::mirror(cur_r_q - half + lrcm_pkg::pos_t'(k_q), h_eff);
    cc      = lrcm_pkg::mirror(cur_c_q - half + lrcm_pkg::pos_t'(l_q), w_eff);
    row_gap = rin_q - rr;
    d_s     = row_gap[SlotW:0];
    s_ext   = {1'b0, slot_q};
    if (s_ext >= d_s) begin
      s_fix = s_ext - d_s;
    end else begin
      s_fix = s_ext + (SlotW+1)'(MAX_WINDOW) - d_s;
    end
    raddr = AddrW'(s_fix[SlotW-1:0]) * AddrW'(MAX_WIDTH) + AddrW'(cc[ColIdxW-1:0]);
  end

  lrcm_pkg::spx_t rdata, chain_res;
  logic [5:0]     nsq;
  logic [RankW-1:0] tgt;

  assign nsq = 6'(ws_q) * 6'(ws_q);
  assign tgt = RankW'(nsq >> 1);

  lrcm_line_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (wpx),
    .re_i    (state_q == ST_LOAD),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lrcm_rank_chain #(.NumCells(NumCells), .RankW(RankW)) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (state_q == ST_CLR),
    .tgt_i    (tgt),
    .in_vld_i (rd_vld_q),
    .in_px_i  (rdata),
    .res_o    (chain_res)
  );

  // Output beat: loaded from the emit state whenever the register is free or drains.
  logic out_load, run_last;
  lrcm_pkg::spx_t sel_px;

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign run_last = err_q || ((cur_r_q == r1_q) && (cur_c_q == c1_q)) ||
                    (cnt_q == lrcm_pkg::ResCntW'(lrcm_pkg::MaxResults - 1));
  assign sel_px   = err_q ? pass_px_q : chain_res;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!win_ok) begin
            state_d = ST_EMIT;
          end else if (go) begin
            state_d = ST_CLR;
          end
        end
      end
      ST_CLR:  state_d = ST_LOAD;
      ST_LOAD: begin
        if ((k_q == ws_q - 3'd1) && (l_q == ws_q - 3'd1)) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tmr_q == TmrW'(WaitCnt)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = run_last ? ST_IDLE : ST_CLR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= 3'd3;
      width_q     <= 11'd640;
      height_q    <= 13'd480;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_slot_q   <= '0;
      rin_q       <= '0;
      cur_r_q     <= '0;
      cur_c_q     <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      r1_q        <= '0;
      slot_q      <= '0;
      last_r_q    <= 1'b0;
      last_c_q    <= 1'b0;
      err_q       <= 1'b0;
      pass_px_q   <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      l_q         <= '0;
      tmr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_LOAD);

      // Any register write restarts the frame.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lrcm_pkg::CFG_WINDOW: ws_q     <= cfg_data_i[2:0];
          lrcm_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
          lrcm_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
        if (cfg_hit) begin
          in_row_q  <= '0;
          in_col_q  <= '0;
          in_slot_q <= '0;
        end
      end else if (accept) begin
        if (last_c) begin
          in_col_q <= '0;
          if (last_r) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
          end else begin
            in_row_q  <= in_row_q + lrcm_pkg::pos_t'(1);
            in_slot_q <= (32'(in_slot_q) == MAX_WINDOW - 1) ? '0 : in_slot_q + SlotW'(1);
          end
        end else begin
          in_col_q <= in_col_q + lrcm_pkg::pos_t'(1);
        end
      end

      if (accept) begin
        rin_q     <= in_row_q;
        slot_q    <= in_slot_q;
        last_r_q  <= last_r;
        last_c_q  <= last_c;
        err_q     <= !win_ok;
        pass_px_q <= wpx;
        cnt_q     <= '0;
        if (!win_ok) begin
          cur_r_q <= in_row_q;
          cur_c_q <= in_col_q;
        end else begin
          cur_r_q <= (last_r && in_row_q < half) ? '0 : in_row_q - half;
          cur_c_q <= (last_c && in_col_q < half) ? '0 : in_col_q - half;
          c0_q    <= (last_c && in_col_q < half) ? '0 : in_col_q - half;
          r1_q    <= last_r ? in_row_q : in_row_q - half;
          c1_q    <= last_c ? in_col_q : in_col_q - half;
        end
      end

      if (state_q == ST_CLR) begin
        k_q   <= '0;
        l_q   <= '0;
        tmr_q <= '0;
      end else begin
        if (state_q == ST_LOAD || state_q == ST_WAIT) begin
          tmr_q <= tmr_q + TmrW'(1);
        end
        if (state_q == ST_LOAD) begin
          if (l_q == ws_q - 3'd1) begin
            l_q <= '0;
            k_q <= k_q + 3'd1;
          end else begin
            l_q <= l_q + 3'd1;
          end
        end
      end

      if (out_load) begin
        out_valid_q        <= 1'b1;
        out_q.out_row      <= cur_r_q[11:0];
        out_q.out_col      <= cur_c_q[9:0];
        out_q.out_blue     <= sel_px.blue;
        out_q.out_green    <= sel_px.green;
        out_q.out_red      <= sel_px.red;
        out_q.window_error <= err_q;
        out_q.last_of_run  <= run_last;
        out_q.frame_end    <= run_last && last_r_q && last_c_q;
        if (!run_last) begin
          cnt_q <= cnt_q + lrcm_pkg::ResCntW'(1);
          if (cur_c_q == c1_q) begin
            cur_c_q <= c0_q;
            cur_r_q <= cur_r_q + lrcm_pkg::pos_t'(1);
          end else begin
            cur_c_q <= cur_c_q + lrcm_pkg::pos_t'(1);
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/tb_luma_ranked_color_median_filter.sv */
// Self-checking testbench of the luma-ranked colour median filter.
// Depends on lrcm_pkg and the luma_ranked_color_median_filter top level.
// Pixels are streamed with random gaps and stalls, and every result is checked against a predictor.

module tb_luma_ranked_color_median_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreRows = 7;
  localparam int StoreCols = 1024;
  localparam int MaxRows   = 4096;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  lrcm_pkg::pix_t in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i;
  lrcm_pkg::res_t out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [lrcm_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [lrcm_pkg::CfgW-1:0]    cfg_data_i = '0;

  // The receiver stall is the union of the random stall and the long hold.
  logic rand_stall = 1'b0;
  logic long_hold  = 1'b0;
  assign out_stall_i = rand_stall | long_hold;

  luma_ranked_color_median_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: register copies, raster position and the stored words.
  int unsigned win_side = 3;
  int unsigned row_count = 480;
  int unsigned col_count = 640;
  int unsigned next_row, next_col;
  bit [31:0]   luma_store [0:StoreRows*StoreCols-1];
  lrcm_pkg::res_t filtered_due [$];

  int errors, pixels_taken, results_seen, bursts;
  bit in_took;
  bit calm;
  int stall_left, stall_roll;

  // Reflect about the image edges, then clamp whatever is still outside.
  function automatic int reflect(int x, int n);
    int y;
    y = x;
    if (y < 0) y = -y - 1;
    else if (y >= n) y = 2 * n - 1 - y;
    if (y < 0) y = 0;
    if (y > n - 1) y = n - 1;
    return y;
  endfunction

  // Median of the window by luma, a tie ranking the earlier position in row-major order lower.
  function automatic bit [31:0] window_median(int r, int c, int ws, int w, int h);
    bit [31:0] win [0:48];
    int half, n, rank, rr, cc;
    half = ws / 2;
    n = ws * ws;
    for (int k = 0; k < ws; k++) begin
      rr = reflect(r - half + k, h);
      for (int l = 0; l < ws; l++) begin
        cc = reflect(c - half + l, w);
        win[k*ws+l] = luma_store[(rr % StoreRows) * StoreCols + cc];
      end
    end
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++) begin
        if (win[j][31:24] < win[i][31:24] || (win[j][31:24] == win[i][31:24] && j < i)) rank++;
      end
      if (rank == n / 2) return win[i];
    end
    return win[0];
  endfunction

  function automatic lrcm_pkg::res_t make_result(int r, int c, bit [31:0] px, bit err);
    lrcm_pkg::res_t e;
    e = '0;
    e.out_row      = r[11:0];
    e.out_col      = c[9:0];
    e.out_blue     = px[7:0];
    e.out_green    = px[15:8];
    e.out_red      = px[23:16];
    e.window_error = err;
    return e;
  endfunction

  // Store one accepted pixel and queue every filtered pixel that it completes.
  function automatic void predict_pixel(lrcm_pkg::pix_t p);
    int w, h, R, C, ws, half, r0, r1, c0, c1;
    int unsigned luma;
    bit last_r, last_c;
    bit [31:0] px;
    lrcm_pkg::res_t batch [$];
    lrcm_pkg::res_t e;
    w = (col_count < 1) ? 1 : (col_count > StoreCols) ? StoreCols : col_count;
    h = (row_count < 1) ? 1 : (row_count > MaxRows) ? MaxRows : row_count;
    R = (next_row >= h) ? h - 1 : next_row;
    C = (next_col >= w) ? w - 1 : next_col;
    ws = win_side;
    last_r = (R == h - 1);
    last_c = (C == w - 1);
    luma = (7471 * p.pix_blue + 38470 * p.pix_green + 19595 * p.pix_red) >> 16;
    px = {luma[7:0], p.pix_red, p.pix_green, p.pix_blue};
    luma_store[(R % StoreRows) * StoreCols + C] = px;
    if (ws < 3 || ws % 2 == 0 || ws > StoreRows) begin
      batch.push_back(make_result(R, C, px, 1'b1));
    end else begin
      half = ws / 2;
      // Away from the bottom and right edges one window completes; at an edge the
      // remaining rows or columns are flushed with it.
      if (last_r) begin r0 = (R >= half) ? R - half : 0; r1 = R; end
      else begin r0 = R - half; r1 = R - half; end
      if (last_c) begin c0 = (C >= half) ? C - half : 0; c1 = C; end
      else begin c0 = C - half; c1 = C - half; end
      if (r0 >= 0 && c0 >= 0) begin
        for (int r = r0; r <= r1; r++) begin
          for (int c = c0; c <= c1; c++) begin
            if (batch.size() < lrcm_pkg::MaxResults)
              batch.push_back(make_result(r, c, window_median(r, c, ws, w, h), 1'b0));
          end
        end
      end
    end
    if (batch.size() > 0) begin
      e = batch.pop_back();
      e.last_of_run = 1'b1;
      e.frame_end = last_r && last_c;
      batch.push_back(e);
    end
    foreach (batch[i]) filtered_due.push_back(batch[i]);
    if (last_c) begin
      next_col = 0;
      next_row = last_r ? 0 : R + 1;
    end else begin
      next_col = C + 1;
      next_row = R;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Input monitor: a beat is taken at a rising edge with valid high and stall low.
  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      pixels_taken++;
      predict_pixel(in_data_i);
    end
  end

  // Output monitor: each result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (filtered_due.size() == 0) begin
        $error("unexpected result at row %0d column %0d", out_data_o.out_row, out_data_o.out_col);
        errors++;
      end else begin
        lrcm_pkg::res_t want;
        want = filtered_due.pop_front();
        check_field("out_row", want.out_row, out_data_o.out_row);
        check_field("out_col", want.out_col, out_data_o.out_col);
        check_field("out_blue", want.out_blue, out_data_o.out_blue);
        check_field("out_green", want.out_green, out_data_o.out_green);
        check_field("out_red", want.out_red, out_data_o.out_red);
        check_field("window_error", want.window_error, out_data_o.window_error);
        check_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
        check_field("frame_end", want.frame_end, out_data_o.frame_end);
      end
    end
  end

  // Random receiver stall: mostly short, now and then a long stretch, none begun while calm.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rand_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm) begin
      rand_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(99);
      if (stall_roll < 2) stall_left <= $urandom_range(80, 20);
      rand_stall <= (stall_roll < 25);
    end
  end

  // Offer one pixel after a random gap and hold it until the block takes it.
  // Entered and left at a falling edge.
  task automatic send_pixel(lrcm_pkg::pix_t p);
    int roll, gap;
    roll = $urandom_range(99);
    gap = 0;
    if (!calm) begin
      if (roll < 3) gap = $urandom_range(60, 20);
      else if (roll < 25) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(negedge clk_i); while (!in_took);
  endtask

  // Let all due results drain, then cover the time a result-free beat may still take.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (filtered_due.size() > 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // A register write also restarts the frame at row 0, column 0.
  task automatic write_reg(lrcm_pkg::cfg_idx_e idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[lrcm_pkg::CfgW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lrcm_pkg::CFG_WINDOW: win_side = value & 32'h7;
      lrcm_pkg::CFG_WIDTH:  col_count = value & 32'h7FF;
      default:              row_count = value & 32'h1FFF;
    endcase
    next_row = 0;
    next_col = 0;
  endtask

  task automatic configure(int unsigned ws, int unsigned w, int unsigned h);
    write_reg(lrcm_pkg::CFG_WINDOW, ws);
    write_reg(lrcm_pkg::CFG_WIDTH, w);
    write_reg(lrcm_pkg::CFG_HEIGHT, h);
    bursts++;
  endtask

  function automatic lrcm_pkg::pix_t random_pixel();
    return lrcm_pkg::pix_t'($urandom_range(24'hFFFFFF));
  endfunction

  // Stream n pixels; with a palette many pixels share a luma, which exercises ties.
  task automatic send_frame(int n, bit use_palette);
    lrcm_pkg::pix_t palette [3];
    int roll;
    foreach (palette[i]) palette[i] = random_pixel();
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) send_pixel('0);
      else if (roll < 8) send_pixel('1);
      else if (use_palette) send_pixel(palette[$urandom_range(2)]);
      else send_pixel(random_pixel());
    end
    wait_idle();
  endtask

  // Clamped oversize registers: a few extreme pixels, still in the first row, so no results.
  task automatic test_oversize_registers();
    configure(7, 2047, 8191);
    send_pixel('0);
    send_pixel('1);
    send_pixel(lrcm_pkg::pix_t'(24'h00FF00));
    wait_idle();
  endtask

  // Zero sizes clamp to a one-pixel frame: every beat ends the frame.
  task automatic test_single_pixel_frame();
    configure(3, 0, 0);
    send_pixel(lrcm_pkg::pix_t'(24'hFF0000));
    send_pixel(lrcm_pkg::pix_t'(24'h0000FF));
    wait_idle();
  endtask

  // Even windows and windows below three pass each pixel through with the error flag.
  task automatic test_invalid_windows();
    int unsigned bad [5] = '{0, 1, 2, 4, 6};
    foreach (bad[i]) begin
      configure(bad[i], 4, 4);
      send_pixel(random_pixel());
      send_pixel('1);
      wait_idle();
    end
  endtask

  // The receiver holds off for a long stretch while a whole frame is offered, so the
  // output register fills and the block has to stall its input.
  task automatic test_backpressure_fill();
    configure(3, 6, 4);
    calm = 1'b1;
    long_hold <= 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk_i);
        long_hold <= 1'b0;
      end
    join_none
    send_frame(24, 1'b0);
    calm = 1'b0;
  endtask

  // Random frames, mostly valid windows and small sizes, some cut short by a new setting.
  task automatic test_random_frames();
    int unsigned ws, w, h, n;
    int start;
    start = pixels_taken;
    while (pixels_taken - start < 440) begin
      ws = ($urandom_range(99) < 80) ? 3 + 2 * $urandom_range(2) : $urandom_range(7);
      w = ($urandom_range(99) < 90) ? $urandom_range(9, 4) : $urandom_range(3);
      h = ($urandom_range(99) < 90) ? $urandom_range(8, 4) : $urandom_range(3);
      configure(ws, w, h);
      n = ((w < 1) ? 1 : w) * ((h < 1) ? 1 : h);
      if ($urandom_range(99) < 15) n = $urandom_range(n, 1);
      calm = ($urandom_range(99) < 20);
      send_frame(n, $urandom_range(99) < 30);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_oversize_registers();
    test_single_pixel_frame();
    test_invalid_windows();
    test_backpressure_fill();
    test_random_frames();
    wait_idle();
    $display("Checked %0d filtered pixels from %0d input pixels over %0d register settings,",
             results_seen, pixels_taken, bursts);
    $display("including invalid and clamped sizes, ties in luma and a long receiver hold.");
    if (errors == 0) begin
      $display("PASS luma_ranked_color_median_filter");
    end else begin
      $display("FAIL luma_ranked_color_median_filter");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #30ms;
    $display("FAIL luma_ranked_color_median_filter");
    $finish;
  end

endmodule
